// ===== rtl/core/kth_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kth_pkg
// Shared widths, defaults and control types for the k-th smallest selector.
// ----------------------------------------------------------------------------
package kth_pkg;

	localparam int DATA_W           = 32;
	localparam int RANK_W           = 7;
	localparam int MAX_ELEMENTS_DEF = 64;

	// per-cycle control broadcast to every cell of the chain
	typedef struct packed {
		logic insert;  // insertion-sort the broadcast value into the row
		logic shift;   // move every entry one cell toward the head
	} chain_ctrl_t;

	typedef enum logic [1:0] {
		ST_LOAD   = 2'b01,
		ST_SELECT = 2'b10
	} sel_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/kth_smallest_select.sv =====
`default_nettype none
// Flow: a value that is not last is sorted into the cell row when it is
//   accepted; a new one can follow every cycle while loading. A last item
//   makes the row shift toward the head until the requested rank is at
//   cell 0; the result loads once the output is free; errors skip shifts.
// Throughput: 1 value per cycle while loading; the rank readout holds off input.
// Reset: arst_n clears count, overflow flag, state and output valid at once.
// ----------------------------------------------------------------------------
// kth_smallest_select
// Streams a set into an insertion-sorting cell row and returns the value
// of the requested 1-based rank on the last transaction of the set.
// ----------------------------------------------------------------------------
module kth_smallest_select #(
	parameter int MAX_ELEMENTS = kth_pkg::MAX_ELEMENTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [kth_pkg::DATA_W-1:0] value,
	input  wire logic [kth_pkg::RANK_W-1:0]        rank,
	input  wire logic                              last,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [kth_pkg::DATA_W-1:0]      selected,
	output logic                                   error
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W = (CNT_W > kth_pkg::RANK_W) ? CNT_W : kth_pkg::RANK_W;

	kth_pkg::sel_state_t  state_q;
	kth_pkg::chain_ctrl_t ctrl;

	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  shift_cnt_q;
	logic                              overflow_q;
	logic                              err_q;
	logic                              out_valid_q;
	logic signed [kth_pkg::DATA_W-1:0] selected_q;
	logic                              error_q;
	logic signed [kth_pkg::DATA_W-1:0] head;

	logic             acc;
	logic             full;
	logic [CMP_W-1:0] new_cnt;
	logic [CMP_W-1:0] rank_x;
	logic             set_err;
	logic             emit;

	assign in_ready = (state_q == kth_pkg::ST_LOAD);
	assign acc      = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(MAX_ELEMENTS));

	assign new_cnt = CMP_W'(count_q) + CMP_W'(!full);
	assign rank_x  = CMP_W'(rank);
	assign set_err = overflow_q || full || (rank == '0) || (rank_x > new_cnt);

	assign ctrl.insert = acc && !full;
	assign ctrl.shift  = (state_q == kth_pkg::ST_SELECT) && (shift_cnt_q != '0);

	assign emit = (state_q == kth_pkg::ST_SELECT) && (shift_cnt_q == '0) &&
	              (!out_valid_q || out_ready);

	kth_chain #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.ins_value(value),
		.count    (count_q),
		.head     (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kth_pkg::ST_LOAD;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			shift_cnt_q <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				kth_pkg::ST_LOAD: begin
					if (acc) begin
						if (last) begin
							// store empties now; readout shifts the row toward the head
							count_q     <= '0;
							overflow_q  <= 1'b0;
							err_q       <= set_err;
							shift_cnt_q <= set_err ? '0 : CNT_W'(rank_x - CMP_W'(1));
							state_q     <= kth_pkg::ST_SELECT;
						end else if (full) begin
							overflow_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				kth_pkg::ST_SELECT: begin
					if (shift_cnt_q != '0) begin
						shift_cnt_q <= shift_cnt_q - CNT_W'(1);
					end else if (emit) begin
						state_q <= kth_pkg::ST_LOAD;
					end
				end
				default: begin
					state_q <= kth_pkg::ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			selected_q <= err_q ? '0 : head;
			error_q    <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign selected  = selected_q;
	assign error     = error_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count above capacity");

	a_select_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kth_pkg::ST_SELECT) |-> (count_q == '0 && !overflow_q))
		else $error("store not emptied during readout");

	a_shift_stays: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |=> (state_q == kth_pkg::ST_SELECT))
		else $error("readout left before shifts finished");

	a_err_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kth_pkg::ST_SELECT && err_q) |-> (shift_cnt_q == '0))
		else $error("error result waits on shifts");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result load lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/kth_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kth_cell
// One entry of the sorted row: insertion by compare against a broadcast
// value, and a shift toward the head for readout.
// ----------------------------------------------------------------------------
module kth_cell (
	input  wire logic                              clk,
	input  wire kth_pkg::chain_ctrl_t              ctrl,
	input  wire logic signed [kth_pkg::DATA_W-1:0] ins_value,
	input  wire logic                              occupied,
	input  wire logic signed [kth_pkg::DATA_W-1:0] lower_value,
	input  wire logic                              lower_gt,
	input  wire logic signed [kth_pkg::DATA_W-1:0] upper_value,
	output logic signed [kth_pkg::DATA_W-1:0]      value_q,
	output logic                                   gt
);

	// this entry is valid and sorts after the incoming value
	assign gt = occupied && (value_q > ins_value);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= upper_value;
		end else if (ctrl.insert) begin
			if (lower_gt) begin
				value_q <= lower_value;
			end else if (gt || !occupied) begin
				value_q <= ins_value;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/kth_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kth_chain
// Row of MAX_ELEMENTS cells kept in ascending signed order, head at cell 0.
// ----------------------------------------------------------------------------
module kth_chain #(
	parameter int MAX_ELEMENTS = kth_pkg::MAX_ELEMENTS_DEF,
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
	input  wire logic                              clk,
	input  wire kth_pkg::chain_ctrl_t              ctrl,
	input  wire logic signed [kth_pkg::DATA_W-1:0] ins_value,
	input  wire logic [CNT_W-1:0]                  count,
	output logic signed [kth_pkg::DATA_W-1:0]      head
);

	logic signed [kth_pkg::DATA_W-1:0] vals [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]           gts;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic signed [kth_pkg::DATA_W-1:0] lower_v;
		logic signed [kth_pkg::DATA_W-1:0] upper_v;
		logic                              lower_g;
		logic                              occ;

		if (i == 0) begin : g_head
			assign lower_v = '0;
			assign lower_g = 1'b0;
		end else begin : g_mid
			assign lower_v = vals[i-1];
			assign lower_g = gts[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_tail
			assign upper_v = vals[i];
		end else begin : g_body
			assign upper_v = vals[i+1];
		end

		assign occ = CNT_W'(i) < count;

		kth_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.ins_value  (ins_value),
			.occupied   (occ),
			.lower_value(lower_v),
			.lower_gt   (lower_g),
			.upper_value(upper_v),
			.value_q    (vals[i]),
			.gt         (gts[i])
		);
	end

	assign head = vals[0];

endmodule
`default_nettype wire
